### hdl/cbst_pkg.sv
// Cell burn switch test: shared widths, register indexes and the
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package cbst_pkg;

    localparam int W_WEIGHT   = 16;
    localparam int W_MASS     = 32;
    localparam int W_TEMP     = 16;
    localparam int W_WM       = 32;
    localparam int W_MSUM     = 35;
    localparam int W_HSUM     = 51;
    localparam int W_CFG_IDX  = 2;
    localparam int W_CFG_DATA = 32;
    localparam int W_IN_DATA  = 64;
    localparam int W_OUT_DATA = 8;

    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_MIN_PEAK   = 2'd1,
        CFG_MASS_FLOOR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic acc;
        logic prod;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic out_free;
    } t_stat;

endpackage

### hdl/cbst_ctrl.sv
// Cell burn switch test controller: sequences multiply, accumulate,
// threshold product and verdict steps. Depends on cbst_pkg.
`timescale 1ns / 1ps

module cbst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cbst_pkg::t_stat i_stat,
    output cbst_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_PROD,
        S_VERD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc  = 1'b1;
                o_in_ready = !i_stat.close;
                if (i_stat.close) begin
                    n_state = S_PROD;
                end else if (i_in_valid) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_VERD;
            end
            S_VERD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.load_in = o_in_ready && i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/cbst_dp.sv
// Cell burn switch test datapath: config registers, weighted mass,
// per-cell accumulators, verdict and output register. Depends on cbst_pkg.
`timescale 1ns / 1ps

module cbst_dp #(
    parameter int NODES_PER_CELL = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbst_pkg::W_CFG_IDX-1:0]      i_cfg_addr,
    input  logic [cbst_pkg::W_CFG_DATA-1:0]     i_cfg_wdata,
    input  logic [cbst_pkg::W_WEIGHT-1:0]       i_weight,
    input  logic [cbst_pkg::W_MASS-1:0]         i_mass,
    input  logic [cbst_pkg::W_TEMP-1:0]         i_temp,
    input  logic                                i_last_node,
    input  logic                                i_last_cell,
    input  cbst_pkg::t_cmd                      i_cmd,
    output cbst_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_cell_met,
    output logic                                o_switch_now,
    output logic                                o_scan_done
);

    localparam int CW = (NODES_PER_CELL > 1) ? $clog2(NODES_PER_CELL) : 1;
    localparam logic [CW-1:0] LAST_CNT = CW'(NODES_PER_CELL - 1);
    localparam int WP = cbst_pkg::W_WEIGHT + cbst_pkg::W_MASS;
    localparam int WH = cbst_pkg::W_WM + cbst_pkg::W_TEMP;

    logic [cbst_pkg::W_TEMP-1:0] r_thr;
    logic [cbst_pkg::W_WM-1:0]   r_min_peak;
    logic [cbst_pkg::W_WM-1:0]   r_floor;

    logic [cbst_pkg::W_WEIGHT-1:0] r_w;
    logic [cbst_pkg::W_MASS-1:0]   r_m;
    logic [cbst_pkg::W_TEMP-1:0]   r_t;
    logic                          r_ln;
    logic                          r_lc;

    logic [cbst_pkg::W_WM-1:0]   r_wm;
    logic [cbst_pkg::W_TEMP-1:0] r_t2;
    logic                        r_close;
    logic                        r_lc2;

    logic [CW-1:0]               r_cnt;
    logic [cbst_pkg::W_WM-1:0]   r_peak;
    logic [cbst_pkg::W_WM-1:0]   r_least;
    logic [cbst_pkg::W_MSUM-1:0] r_msum;
    logic [cbst_pkg::W_HSUM-1:0] r_hsum;
    logic [cbst_pkg::W_HSUM-1:0] r_tm;

    logic r_sw;
    logic r_out_valid;
    logic r_met;
    logic r_swn;
    logic r_done;

    logic [WP-1:0]               w_wm_prod;
    logic [cbst_pkg::W_WM-1:0]   w_wm;
    logic [WH-1:0]               w_heat_prod;
    logic                        w_first;
    logic [cbst_pkg::W_WM-1:0]   w_peak_base;
    logic [cbst_pkg::W_WM-1:0]   w_least_base;
    logic [cbst_pkg::W_MSUM-1:0] w_msum_base;
    logic [cbst_pkg::W_HSUM-1:0] w_hsum_base;
    logic [cbst_pkg::W_MSUM:0]   w_msum_add;
    logic [cbst_pkg::W_HSUM:0]   w_hsum_add;
    logic [cbst_pkg::W_WM-1:0]   w_spread;
    logic [cbst_pkg::W_MSUM-1:0] w_spread5;
    logic [cbst_pkg::W_MSUM-1:0] w_peak2;
    logic                        w_hot;
    logic                        w_met;

    always_comb begin
        w_wm_prod    = WP'(r_w) * WP'(r_m);
        w_wm         = w_wm_prod[WP-1] ? '1 : w_wm_prod[WP-2:cbst_pkg::W_WEIGHT-1];
        w_heat_prod  = WH'(r_wm) * WH'(r_t2);
        w_first      = (r_cnt == '0);
        w_peak_base  = w_first ? r_floor : r_peak;
        w_least_base = w_first ? '1 : r_least;
        w_msum_base  = w_first ? '0 : r_msum;
        w_hsum_base  = w_first ? '0 : r_hsum;
        w_msum_add   = (cbst_pkg::W_MSUM + 1)'(w_msum_base) + (cbst_pkg::W_MSUM + 1)'(r_wm);
        w_hsum_add   = (cbst_pkg::W_HSUM + 1)'(w_hsum_base)
                     + (cbst_pkg::W_HSUM + 1)'(w_heat_prod);
        w_spread     = r_peak - r_least;
        w_spread5    = {3'b000, w_spread} + {1'b0, w_spread, 2'b00};
        w_peak2      = {2'b00, r_peak, 1'b0};
        w_hot        = (r_msum == '0) ? (r_thr == '0) : (r_hsum >= r_tm);
        w_met        = (r_peak != '0) && (w_spread5 > w_peak2) && (r_least != '0)
                     && (r_peak > r_min_peak) && w_hot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= '0;
            r_min_peak  <= '0;
            r_floor     <= cbst_pkg::W_WM'(1);
            r_cnt       <= '0;
            r_sw        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    cbst_pkg::CFG_THRESHOLD:  r_thr      <= i_cfg_wdata[cbst_pkg::W_TEMP-1:0];
                    cbst_pkg::CFG_MIN_PEAK:   r_min_peak <= i_cfg_wdata;
                    cbst_pkg::CFG_MASS_FLOOR: r_floor    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.acc) begin
                r_cnt <= r_close ? '0 : r_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_sw        <= r_lc2 ? 1'b0 : (r_sw | w_met);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_w  <= i_weight;
            r_m  <= i_mass;
            r_t  <= i_temp;
            r_ln <= i_last_node;
            r_lc <= i_last_cell;
        end
        if (i_cmd.mul) begin
            r_wm    <= w_wm;
            r_t2    <= r_t;
            r_close <= r_ln || (r_cnt == LAST_CNT);
            r_lc2   <= r_lc;
        end
        if (i_cmd.acc) begin
            r_peak  <= (r_wm > w_peak_base) ? r_wm : w_peak_base;
            r_least <= (r_wm < w_least_base) ? r_wm : w_least_base;
            r_msum  <= w_msum_add[cbst_pkg::W_MSUM] ? '1 : w_msum_add[cbst_pkg::W_MSUM-1:0];
            r_hsum  <= w_hsum_add[cbst_pkg::W_HSUM] ? '1 : w_hsum_add[cbst_pkg::W_HSUM-1:0];
        end
        if (i_cmd.prod) begin
            r_tm <= cbst_pkg::W_HSUM'(r_thr) * cbst_pkg::W_HSUM'(r_msum);
        end
        if (i_cmd.emit) begin
            r_met  <= w_met;
            r_swn  <= r_sw | w_met;
            r_done <= r_lc2;
        end
    end

    assign o_stat.close    = r_close;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cell_met      = r_met;
    assign o_switch_now    = r_swn;
    assign o_scan_done     = r_done;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_CNT)
        else $error("node count past cell length");
    a_least_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |=> (r_least <= r_peak))
        else $error("least mass above peak mass");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("verdict lost at output register");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("verdict overwrites pending result");
`endif

endmodule

### hdl/cell_burn_switch_test.sv
// Cell burn switch test top level: stream ports, config port, controller
// and datapath. Depends on cbst_pkg, cbst_ctrl and cbst_dp.
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/tready        tdata, tlast = last_node, tuser = last_cell
//   m_axis    out  m_axis_tvalid/tready        tdata, tlast = scan_done
//   cfg       in   i_cfg_we                    i_cfg_addr, i_cfg_wdata
//
// Each node runs a multiply step for the weight times mass product, then an accumulate step
// with the mass times temperature product; the next node is taken in that step unless the
// cell closes. A closing node then runs the threshold times mass-sum product and the verdict,
// and the controller returns to idle before the next node is taken.
// The verdict waits while the output register holds an untaken result.
// Reset is synchronous and active low; nothing needs a clearing pass.
`timescale 1ns / 1ps

module cell_burn_switch_test #(
    parameter int NODES_PER_CELL = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] node_weight, [47:16] node_mass, [63:48] node_temperature
    input  logic [cbst_pkg::W_IN_DATA-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    // [0] last_cell
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] cell_met, [1] switch_now, [7:2] zero
    output logic [cbst_pkg::W_OUT_DATA-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [cbst_pkg::W_CFG_IDX-1:0]      i_cfg_addr,
    input  logic [cbst_pkg::W_CFG_DATA-1:0]     i_cfg_wdata
);

    cbst_pkg::t_cmd  w_cmd;
    cbst_pkg::t_stat w_stat;
    logic            w_met;
    logic            w_swn;

    cbst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cbst_dp #(
        .NODES_PER_CELL (NODES_PER_CELL)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_weight     (s_axis_tdata[15:0]),
        .i_mass       (s_axis_tdata[47:16]),
        .i_temp       (s_axis_tdata[63:48]),
        .i_last_node  (s_axis_tlast),
        .i_last_cell  (s_axis_tuser),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_cell_met   (w_met),
        .o_switch_now (w_swn),
        .o_scan_done  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b000000, w_swn, w_met};

endmodule
